@@ src/parity_fault_injection_tracker_defines.svh @@
// assertion macros used by the checker file pfit_checker.sv
`ifndef PARITY_FAULT_INJECTION_TRACKER_DEFINES_SVH
`define PARITY_FAULT_INJECTION_TRACKER_DEFINES_SVH

// checked only while out of reset
`define PFIT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: property failed");

// checked at every edge, also in reset
`define PFIT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: property failed");

`endif

@@ src/pfit_pkg.sv @@
package pfit_pkg;

	localparam int unsigned MAX_RAM_BYTES_DEF = 1048576;

	localparam int unsigned SIZE_W     = 21;
	localparam int unsigned OFFSET_W   = 32;
	localparam int unsigned LANES_W    = 4;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned FLAG_W     = 8;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned LANE_SEL_W = 2;
	localparam int unsigned BIT_SEL_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PARITY_FITTED = 1'b0,
		REG_MEMORY_SIZE   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_CHECK = 1'b1
	} op_t;

	typedef struct packed {
		logic              fitted;
		logic [SIZE_W-1:0] size;
		logic              clearing;
	} cfg_state_t;

endpackage

@@ src/pfit_flag_mem.sv @@
module pfit_flag_mem
	import pfit_pkg::*;
#(
	parameter int unsigned DEPTH = (MAX_RAM_BYTES_DEF + 7) / 8,
	parameter int unsigned AW    = $clog2((MAX_RAM_BYTES_DEF + 7) / 8)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [FLAG_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [FLAG_W-1:0] rdata
);

	logic [FLAG_W-1:0] mem_q [DEPTH];
	logic [FLAG_W-1:0] rdata_q;

	// read-first: a read and a write of the same entry return the old byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/pfit_cfg.sv @@
module pfit_cfg
	import pfit_pkg::*;
#(
	parameter int unsigned DEPTH = (MAX_RAM_BYTES_DEF + 7) / 8,
	parameter int unsigned AW    = $clog2((MAX_RAM_BYTES_DEF + 7) / 8)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [SIZE_W-1:0]    cfg_data,
	output cfg_state_t           cfg,
	output logic [AW-1:0]        clr_addr
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic              fitted_q;
	logic [SIZE_W-1:0] size_q;
	logic              clearing_q;
	logic [AW-1:0]     clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fitted_q   <= 1'b0;
			size_q     <= '0;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_idx))
					REG_PARITY_FITTED: begin
						fitted_q <= cfg_data[0];
					end
					REG_MEMORY_SIZE: begin
						size_q <= cfg_data;
					end
				endcase
			end
			// a new size restarts the sweep from the first flag byte
			if (cfg_we && (cfg_reg_t'(cfg_idx) == REG_MEMORY_SIZE)) begin
				clearing_q <= 1'b1;
				clr_addr_q <= '0;
			end else if (clearing_q) begin
				// sweep one flag byte per cycle
				if (clr_addr_q == LAST_ADDR) begin
					clearing_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + AW'(1);
				end
			end
		end
	end

	assign cfg.fitted   = fitted_q;
	assign cfg.size     = size_q;
	assign cfg.clearing = clearing_q;
	assign clr_addr     = clr_addr_q;

endmodule

@@ src/pfit_update.sv @@
module pfit_update
	import pfit_pkg::*;
#(
	parameter int unsigned MAX_RAM_BYTES = MAX_RAM_BYTES_DEF,
	parameter int unsigned AW            = $clog2((MAX_RAM_BYTES_DEF + 7) / 8)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                opcode,
	input  logic [OFFSET_W-1:0] byte_offset,
	input  logic [LANES_W-1:0]  lane_force,
	input  cfg_state_t          cfg,
	input  logic [FLAG_W-1:0]   rd_data,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [FLAG_W-1:0]   wr_data,
	output logic                done,
	output logic                error_hit,
	output logic [COUNT_W-1:0]  error_total,
	output logic [COUNT_W-1:0]  first_fault_offset,
	output logic [COUNT_W-1:0]  forced_total,
	output logic [COUNT_W-1:0]  unstorable_total
);

	localparam logic [OFFSET_W-1:0] MAX_LIMIT = OFFSET_W'(MAX_RAM_BYTES);

	// covered range, size saturated at the flag memory capacity
	logic [OFFSET_W-1:0] size_ext;
	logic [OFFSET_W-1:0] limit;
	logic                ok_s0;

	assign size_ext = OFFSET_W'(cfg.size);
	assign limit    = (size_ext > MAX_LIMIT) ? MAX_LIMIT : size_ext;
	assign ok_s0    = cfg.fitted && (byte_offset < limit);

	logic                valid_s1;
	op_t                 op_s1;
	logic [OFFSET_W-1:0] off_s1;
	logic [LANES_W-1:0]  lanes_s1;
	logic                ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_t'(opcode);
			off_s1   <= byte_offset;
			lanes_s1 <= lane_force;
			ok_s1    <= ok_s0;
		end
	end

	// the byte written at the last edge, for a read that raced it
	logic              fwd_valid_q;
	logic [AW-1:0]     fwd_addr_q;
	logic [FLAG_W-1:0] fwd_data_q;

	logic [AW-1:0]     addr_s1;
	logic [FLAG_W-1:0] cur_byte;
	logic [FLAG_W-1:0] bit_mask;
	logic              forcing;
	logic              flag_set;
	logic              is_write;
	logic              hit;

	always_comb begin
		addr_s1  = off_s1[AW+BIT_SEL_W-1:BIT_SEL_W];
		cur_byte = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_data;
		bit_mask = FLAG_W'(1) << off_s1[BIT_SEL_W-1:0];
		forcing  = lanes_s1[off_s1[LANE_SEL_W-1:0]];
		flag_set = |(cur_byte & bit_mask);
		is_write = (op_s1 == OP_WRITE);
		wr_en    = valid_s1 && is_write && ok_s1;
		wr_addr  = addr_s1;
		wr_data  = forcing ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
		hit      = valid_s1 && (op_s1 == OP_CHECK) && ok_s1 && flag_set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= wr_addr;
		fwd_data_q <= wr_data;
	end

	logic               done_q;
	logic               hit_q;
	logic [COUNT_W-1:0] error_count_q;
	logic [COUNT_W-1:0] first_error_q;
	logic [COUNT_W-1:0] forced_count_q;
	logic [COUNT_W-1:0] unstorable_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q             <= 1'b0;
			hit_q              <= 1'b0;
			error_count_q      <= '0;
			first_error_q      <= '0;
			forced_count_q     <= '0;
			unstorable_count_q <= '0;
		end else begin
			done_q <= valid_s1;
			hit_q  <= hit;
			if (valid_s1 && is_write && forcing) begin
				forced_count_q <= forced_count_q + COUNT_W'(1);
				if (!ok_s1) begin
					unstorable_count_q <= unstorable_count_q + COUNT_W'(1);
				end
			end
			if (hit) begin
				if (error_count_q == '0) begin
					first_error_q <= off_s1;
				end
				error_count_q <= error_count_q + COUNT_W'(1);
			end
		end
	end

	assign done               = done_q;
	assign error_hit          = hit_q;
	assign error_total        = error_count_q;
	assign first_fault_offset = first_error_q;
	assign forced_total       = forced_count_q;
	assign unstorable_total   = unstorable_count_q;

endmodule

@@ src/parity_fault_injection_tracker.sv @@
// Tracks one bad-parity flag per RAM byte, eight flags to a byte of an on-chip
// flag memory. While busy is low the block takes one access per clock; its
// result is registered after the read stage, appears for one cycle, marked by
// done, and cannot be held off. The flag memory has a registered read, and the
// byte written by an access is forwarded to the very next one. busy is high
// after reset and after every write of memory_size_bytes, while the flag
// memory is swept to zero one byte per cycle; configuration writes are still
// taken then.
module parity_fault_injection_tracker
	import pfit_pkg::*;
#(
	parameter int unsigned MAX_RAM_BYTES = MAX_RAM_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic                 opcode,
	input  logic [OFFSET_W-1:0]  byte_offset,
	input  logic [LANES_W-1:0]   lane_force,
	output logic                 done,
	output logic                 error_hit,
	output logic [COUNT_W-1:0]   error_total,
	output logic [COUNT_W-1:0]   first_fault_offset,
	output logic [COUNT_W-1:0]   forced_total,
	output logic [COUNT_W-1:0]   unstorable_total
);

	localparam int unsigned FLAG_BYTES = (MAX_RAM_BYTES + 7) / 8;
	localparam int unsigned AW         = (FLAG_BYTES > 1) ? $clog2(FLAG_BYTES) : 1;

	cfg_state_t        cfg;
	logic [AW-1:0]     clr_addr;
	logic              accept;
	logic              item_we;
	logic [AW-1:0]     item_addr;
	logic [FLAG_W-1:0] item_data;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [FLAG_W-1:0] mem_wdata;
	logic [FLAG_W-1:0] mem_rdata;

	assign busy   = cfg.clearing;
	assign accept = start && !cfg.clearing;

	// the sweep owns the write port; an in-flight access loses its write
	always_comb begin
		if (cfg.clearing) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr;
			mem_wdata = '0;
		end else begin
			mem_we    = item_we;
			mem_waddr = item_addr;
			mem_wdata = item_data;
		end
	end

	pfit_cfg #(
		.DEPTH (FLAG_BYTES),
		.AW    (AW)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.clr_addr (clr_addr)
	);

	pfit_flag_mem #(
		.DEPTH (FLAG_BYTES),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (byte_offset[AW+BIT_SEL_W-1:BIT_SEL_W]),
		.rdata (mem_rdata)
	);

	pfit_update #(
		.MAX_RAM_BYTES (MAX_RAM_BYTES),
		.AW            (AW)
	) u_update (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.opcode             (opcode),
		.byte_offset        (byte_offset),
		.lane_force         (lane_force),
		.cfg                (cfg),
		.rd_data            (mem_rdata),
		.wr_en              (item_we),
		.wr_addr            (item_addr),
		.wr_data            (item_data),
		.done               (done),
		.error_hit          (error_hit),
		.error_total        (error_total),
		.first_fault_offset (first_fault_offset),
		.forced_total       (forced_total),
		.unstorable_total   (unstorable_total)
	);

endmodule

@@ src/pfit_checker.sv @@
`include "parity_fault_injection_tracker_defines.svh"

module pfit_checker
	import pfit_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [SIZE_W-1:0]    cfg_data,
	input logic                 start,
	input logic                 busy,
	input logic                 opcode,
	input logic [OFFSET_W-1:0]  byte_offset,
	input logic [LANES_W-1:0]   lane_force,
	input logic                 done,
	input logic                 error_hit,
	input logic [COUNT_W-1:0]   error_total,
	input logic [COUNT_W-1:0]   first_fault_offset,
	input logic [COUNT_W-1:0]   forced_total,
	input logic [COUNT_W-1:0]   unstorable_total
);

	// every accepted beat gives exactly one result, and every result has an accepted beat
	`PFIT_ASSERT(a_result_follows, (start && !busy) |-> ##2 done)
	`PFIT_ASSERT(a_result_has_beat, done |-> $past(start && !busy, 2))
	`PFIT_ASSERT_ALWAYS(a_hit_only_on_result, error_hit |-> done)
	`PFIT_ASSERT(a_errors_move_on_result, !done |-> $stable(error_total))
	`PFIT_ASSERT(a_hit_counts_one,
		(done && error_hit) |-> (error_total == COUNT_W'($past(error_total) + COUNT_W'(1))))

endmodule

bind parity_fault_injection_tracker pfit_checker u_pfit_checker (.*);
